// ===== hdl/radio_time_code_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Radio time code decoder assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef RADIO_TIME_CODE_DECODER_MACROS_SVH
`define RADIO_TIME_CODE_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define RTCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that a condition holds in the cycle after a trigger
`define RTCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RTCD_ASSERT(label, clk, rst, prop, msg)
`define RTCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/rtcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Radio time code decoder package
// Item types, register indexes and telegram constants shared by the block.
// ----------------------------------------------------------------------------
package rtcd_pkg;

   // telegram length and bit counter limits
   localparam int TELEGRAM_BITS = 59;
   localparam logic [5:0] BIT_COUNT_FULL = 6'(TELEGRAM_BITS);
   localparam logic [5:0] BIT_COUNT_MAX  = 6'(TELEGRAM_BITS + 1);

   // year handling
   localparam logic [11:0] YEAR_BASE       = 12'd2000;
   localparam logic [7:0]  YEAR_DIGITS_MIN = 8'd11;

   // configuration register indexes
   localparam logic [1:0] CSR_ONE_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_ZERO_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_SYNC_PAUSE     = 2'd2;

   // configuration reset values
   localparam logic [9:0]  ONE_THRESHOLD_RESET  = 10'd150;
   localparam logic [9:0]  ZERO_THRESHOLD_RESET = 10'd50;
   localparam logic [11:0] SYNC_PAUSE_RESET     = 12'd1500;

   typedef struct packed {
      logic        signal_level;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic        telegram_ok;
      logic [6:0]  minute_value;
      logic [5:0]  hour_value;
      logic [5:0]  day_of_month;
      logic [2:0]  weekday_value;
      logic [4:0]  month_value;
      logic [11:0] year_value;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0]  minute;
      logic [5:0]  hour;
      logic [5:0]  day;
      logic [2:0]  weekday;
      logic [4:0]  month;
      logic [11:0] year;
   } time_fields_type;

   typedef struct packed {
      logic            ok;
      time_fields_type fields;
   } decode_result_type;

   // control for one cell of the bit chain
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

// ===== hdl/rtcd_cell.sv =====
// ----------------------------------------------------------------------------
// Radio time code decoder bit cell
// One stage of the telegram bit chain: holds one bit, takes its neighbour's.
// ----------------------------------------------------------------------------
module rtcd_cell
   import rtcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          bit_in,
   output logic          bit_out
);

   logic bit_ff;
   logic bit_in_next;

   // clear on minute end, shift on a new bit, otherwise hold
   always_comb begin
      priority if (ctrl.clear) begin
         bit_in_next = 1'b0;
      end else if (ctrl.shift) begin
         bit_in_next = bit_in;
      end else begin
         bit_in_next = bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in_next;
      end
   end

   assign bit_out = bit_ff;

endmodule

// ===== hdl/rtcd_decode.sv =====
// ----------------------------------------------------------------------------
// Radio time code decoder telegram decode
// Weighted BCD sums, parity and plausibility checks over a full telegram.
// ----------------------------------------------------------------------------
module rtcd_decode
   import rtcd_pkg::*;
(
   input  logic [TELEGRAM_BITS-1:0] tel_bits,
   output decode_result_type        result
);

   // weights 1,2,4,8 on the low digit and 10,20,40,80 on the high digit
   function automatic logic [7:0] bcd_sum(input logic [7:0] digits);
      logic [7:0] tens;
      tens = {4'b0000, digits[7:4]};
      return (tens << 3) + (tens << 1) + {4'b0000, digits[3:0]};
   endfunction

   logic [7:0] year_digits;
   logic       start_ok;
   logic       minute_par_ok;
   logic       hour_par_ok;
   logic       date_par_ok;
   logic       year_ok;

   assign year_digits = bcd_sum(tel_bits[57:50]);

   // checks: start bit, Z1/Z2 differ, even parity groups, plausible year
   assign start_ok      = tel_bits[20] && (tel_bits[17] != tel_bits[18]);
   assign minute_par_ok = ~^tel_bits[28:21];
   assign hour_par_ok   = ~^tel_bits[35:29];
   assign date_par_ok   = ~^tel_bits[58:36];
   assign year_ok       = year_digits >= YEAR_DIGITS_MIN;

   always_comb begin
      result.ok             = start_ok && minute_par_ok && hour_par_ok
                              && date_par_ok && year_ok;
      result.fields.minute  = 7'(bcd_sum({1'b0, tel_bits[27:21]}));
      result.fields.hour    = 6'(bcd_sum({2'b00, tel_bits[34:29]}));
      result.fields.day     = 6'(bcd_sum({2'b00, tel_bits[41:36]}));
      result.fields.weekday = tel_bits[44:42];
      result.fields.month   = 5'(bcd_sum({3'b000, tel_bits[49:45]}));
      result.fields.year    = {4'b0000, year_digits} + YEAR_BASE;
   end

endmodule

// ===== hdl/radio_time_code_decoder.sv =====
// A result item is registered in the cycle after its item is accepted.
// Throughput: one item per cycle while the result register is empty or being
// emptied; pulse timing, chain control and telegram decode are combinational.
// Reset (synchronous, active high) clears the bit chain, counters, timestamps
// and decoded values, and loads thresholds 150 ms, 50 ms and sync pause 1500 ms.
// ----------------------------------------------------------------------------
// Radio time code decoder
// Measures receiver pulse widths, shifts bits through a chain of cells and
// decodes the minute telegram when a sync pause ends the minute.
// ----------------------------------------------------------------------------
`include "radio_time_code_decoder_macros.svh"

module radio_time_code_decoder
   import rtcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   // result items
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   // configuration writes
   input  logic         csr_write_en,
   input  logic [1:0]   csr_index,
   input  logic [11:0]  csr_write_data
);

   // configuration registers
   logic [9:0]  one_thresh_ff,  one_thresh_in;
   logic [9:0]  zero_thresh_ff, zero_thresh_in;
   logic [11:0] sync_pause_ff,  sync_pause_in;

   // pulse timing state
   logic [5:0]  bit_count_ff,   bit_count_in;
   logic        level_high_ff,  level_high_in;
   logic [31:0] pulse_start_ff, pulse_start_in;
   logic [31:0] pulse_stop_ff,  pulse_stop_in;

   // decoded values and result register
   time_fields_type decoded_ff, decoded_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_item_ff, rsp_item_in;

   logic                     accept;
   logic [31:0]              pulse_width;
   logic [31:0]              pause_len;
   logic                     record;
   logic                     record_value;
   logic                     sync_hit;
   logic                     decode_now;
   cell_ctrl_type            cell_ctrl;
   logic [TELEGRAM_BITS-1:0] cell_q;
   logic [TELEGRAM_BITS-1:0] tel_bits;
   decode_result_type        dec_result;

   // take an item while the result register is empty or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // configuration write port
   always_comb begin
      one_thresh_in  = one_thresh_ff;
      zero_thresh_in = zero_thresh_ff;
      sync_pause_in  = sync_pause_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ONE_THRESHOLD:  one_thresh_in  = csr_write_data[9:0];
            CSR_ZERO_THRESHOLD: zero_thresh_in = csr_write_data[9:0];
            CSR_SYNC_PAUSE:     sync_pause_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   // classify the pulse on a falling level
   assign pulse_width = req_item.now_ms - pulse_start_ff;
   always_comb begin
      record       = 1'b0;
      record_value = 1'b0;
      if (!req_item.signal_level && level_high_ff) begin
         priority if (pulse_width > {22'b0, one_thresh_ff}) begin
            record       = 1'b1;
            record_value = 1'b1;
         end else if (pulse_width > {22'b0, zero_thresh_ff}) begin
            record = 1'b1;
         end else begin
            record = 1'b0;
         end
      end
   end

   // a recorded bit restarts the pause timer, so only an idle pause can sync
   assign pause_len  = req_item.now_ms - pulse_stop_ff;
   assign sync_hit   = !record && (pause_len > {20'b0, sync_pause_ff});
   assign decode_now = sync_hit && (bit_count_ff == BIT_COUNT_FULL);

   // bit chain control
   assign cell_ctrl.shift = accept && record && (bit_count_ff < BIT_COUNT_FULL);
   assign cell_ctrl.clear = accept && sync_hit;

   // row of bit cells; the oldest bit sits at the far end
   for (genvar i = 0; i < TELEGRAM_BITS; i++) begin : g_cell
      logic cell_d;
      if (i == 0) begin : g_head
         assign cell_d = record_value;
      end else begin : g_link
         assign cell_d = cell_q[i-1];
      end
      rtcd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (cell_ctrl),
         .bit_in  (cell_d),
         .bit_out (cell_q[i])
      );
      // telegram bit i is the bit shifted in at position i since the last clear
      assign tel_bits[i] = cell_q[TELEGRAM_BITS-1-i];
   end

   rtcd_decode u_decode (
      .tel_bits (tel_bits),
      .result   (dec_result)
   );

   // advance timing state for an accepted item
   always_comb begin
      bit_count_in   = bit_count_ff;
      level_high_in  = level_high_ff;
      pulse_start_in = pulse_start_ff;
      pulse_stop_in  = pulse_stop_ff;
      decoded_in     = decoded_ff;
      if (accept) begin
         if (req_item.signal_level && !level_high_ff) begin
            level_high_in  = 1'b1;
            pulse_start_in = req_item.now_ms;
         end
         if (record) begin
            level_high_in = 1'b0;
            pulse_stop_in = req_item.now_ms;
            if (bit_count_ff < BIT_COUNT_MAX) begin
               bit_count_in = bit_count_ff + 6'd1;
            end
         end
         if (sync_hit) begin
            bit_count_in   = 6'd0;
            level_high_in  = 1'b0;
            pulse_start_in = req_item.now_ms;
            pulse_stop_in  = req_item.now_ms;
         end
         if (decode_now) begin
            decoded_in = dec_result.ok ? dec_result.fields : '0;
         end
      end
   end

   // result register: load on accept, drop when taken
   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_item_in.telegram_ok   = decode_now && dec_result.ok;
         rsp_item_in.minute_value  = decoded_in.minute;
         rsp_item_in.hour_value    = decoded_in.hour;
         rsp_item_in.day_of_month  = decoded_in.day;
         rsp_item_in.weekday_value = decoded_in.weekday;
         rsp_item_in.month_value   = decoded_in.month;
         rsp_item_in.year_value    = decoded_in.year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_thresh_ff  <= ONE_THRESHOLD_RESET;
         zero_thresh_ff <= ZERO_THRESHOLD_RESET;
         sync_pause_ff  <= SYNC_PAUSE_RESET;
         bit_count_ff   <= 6'd0;
         level_high_ff  <= 1'b0;
         pulse_start_ff <= 32'd0;
         pulse_stop_ff  <= 32'd0;
         decoded_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         one_thresh_ff  <= one_thresh_in;
         zero_thresh_ff <= zero_thresh_in;
         sync_pause_ff  <= sync_pause_in;
         bit_count_ff   <= bit_count_in;
         level_high_ff  <= level_high_in;
         pulse_start_ff <= pulse_start_in;
         pulse_stop_ff  <= pulse_stop_in;
         decoded_ff     <= decoded_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // checks on counter range, minute end and decoded year
   `RTCD_ASSERT(a_count_range, clock, reset, bit_count_ff <= BIT_COUNT_MAX, "bit count overrun")
   `RTCD_ASSERT_NEXT(a_sync_clears, clock, reset, accept && sync_hit, bit_count_ff == 6'd0 && !level_high_ff, "minute end did not clear state")
   `RTCD_ASSERT(a_ok_year, clock, reset, !(rsp_valid_ff && rsp_item_ff.telegram_ok) || (rsp_item_ff.year_value >= 12'd2011), "good telegram with implausible year")

endmodule

// ===== dv/tb_radio_time_code_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radio time code decoder testbench
// Feeds timestamped receiver samples through the request channel and predicts
// every result item with an untimed model of the pulse timer, the bit store and
// the telegram decode. Each result field is checked as the item leaves the
// block. Directed samples hit the timestamp extremes and the edge timing
// corners. Random minutes then carry whole telegrams, some of them broken on
// purpose, under several threshold settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_radio_time_code_decoder;
   import rtcd_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int GAP_MAX_MS   = 800;
   // index beyond the three registers; writes to it must change nothing
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // ways a random minute can be spoilt
   typedef enum int {
      FAULT_FLIP_BIT,
      FAULT_SHORT_COUNT,
      FAULT_LONG_COUNT,
      FAULT_EARLY_YEAR,
      FAULT_NO_START,
      FAULT_SAME_ZONE
   } fault_kind_type;

   logic         clock          = 1'b0;
   logic         reset          = 1'b1;
   logic         req_valid      = 1'b0;
   logic         req_ready;
   req_item_type req_item       = '0;
   logic         rsp_valid;
   logic         rsp_ready      = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_write_en   = 1'b0;
   logic [1:0]   csr_index      = CSR_ONE_THRESHOLD;
   logic [11:0]  csr_write_data = '0;

   // predictor copy of the registers and of the block state
   logic [9:0]               cfg_one_ms  = ONE_THRESHOLD_RESET;
   logic [9:0]               cfg_zero_ms = ZERO_THRESHOLD_RESET;
   logic [11:0]              cfg_sync_ms = SYNC_PAUSE_RESET;
   logic [TELEGRAM_BITS-1:0] bit_chain   = '0;
   logic [5:0]               bits_seen   = '0;
   logic                     pulse_open  = 1'b0;
   logic [31:0]              pulse_start = '0;
   logic [31:0]              pulse_stop  = '0;
   rsp_item_type             held_time   = '0;

   req_item_type sample_q[$];
   rsp_item_type expected_time_q[$];
   logic [31:0]  stamp_ms         = '0;
   int unsigned  queued_count     = 0;
   int unsigned  accepted_count   = 0;
   int unsigned  telegrams_passed = 0;
   int unsigned  settings_used    = 1;
   int unsigned  req_hold         = 0;
   int unsigned  rsp_stall        = 0;
   int           cycle_count      = 0;
   int           failures         = 0;

   radio_time_code_decoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // idle length: mostly none, often a few cycles, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sum telegram bits by BCD weight 1, 2, 4, 8, 10, 20, 40, 80
   function automatic int unsigned weighted_sum(logic [TELEGRAM_BITS-1:0] bits,
                                                int first, int len);
      int unsigned sum;
      sum = 0;
      for (int k = 0; k < len; k++)
         if (bits[first + k]) sum += (k < 4) ? (1 << k) : 10 * (1 << (k - 4));
      return sum;
   endfunction

   // advance the predicted state by one sample and return its result item
   function automatic rsp_item_type decode_sample(req_item_type sample);
      logic [31:0]  width;
      logic [31:0]  since_stop;
      int unsigned  year;
      logic         good;
      rsp_item_type result;
      // edge handling: a rise opens the pulse, a long enough fall stores a bit
      if (sample.signal_level) begin
         if (!pulse_open) begin
            pulse_open  = 1'b1;
            pulse_start = sample.now_ms;
         end
      end else if (pulse_open) begin
         width = sample.now_ms - pulse_start;
         if (width > cfg_one_ms || width > cfg_zero_ms) begin
            if (bits_seen < BIT_COUNT_FULL) bit_chain[bits_seen] = (width > cfg_one_ms);
            if (bits_seen < BIT_COUNT_MAX) bits_seen = bits_seen + 6'd1;
            pulse_open = 1'b0;
            pulse_stop = sample.now_ms;
         end
      end
      result = held_time;
      result.telegram_ok = 1'b0;
      // a pause past the sync limit ends the minute, measured from the new stop
      since_stop = sample.now_ms - pulse_stop;
      if (since_stop > cfg_sync_ms) begin
         if (bits_seen == BIT_COUNT_FULL) begin
            year = weighted_sum(bit_chain, 50, 8) + int'(YEAR_BASE);
            good = bit_chain[20] && (bit_chain[17] != bit_chain[18])
                   && !(^bit_chain[28:21]) && !(^bit_chain[35:29])
                   && !(^bit_chain[58:36])
                   && year >= int'(YEAR_BASE) + int'(YEAR_DIGITS_MIN);
            held_time = '0;
            if (good) begin
               held_time.minute_value  = 7'(weighted_sum(bit_chain, 21, 7));
               held_time.hour_value    = 6'(weighted_sum(bit_chain, 29, 6));
               held_time.day_of_month  = 6'(weighted_sum(bit_chain, 36, 6));
               held_time.weekday_value = 3'(weighted_sum(bit_chain, 42, 3));
               held_time.month_value   = 5'(weighted_sum(bit_chain, 45, 5));
               held_time.year_value    = 12'(year);
            end
            result = held_time;
            result.telegram_ok = good;
         end
         bit_chain   = '0;
         bits_seen   = '0;
         pulse_open  = 1'b0;
         pulse_start = sample.now_ms;
         pulse_stop  = sample.now_ms;
      end
      return result;
   endfunction

   function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic logic [7:0] to_bcd(int unsigned value);
      return 8'(((value / 10) << 4) | (value % 10));
   endfunction

   // queue one sample at an absolute timestamp
   task automatic push_at(logic level, logic [31:0] at_ms);
      req_item_type sample;
      stamp_ms            = at_ms;
      sample.signal_level = level;
      sample.now_ms       = at_ms;
      sample_q.push_back(sample);
      queued_count++;
   endtask

   // queue a whole minute: flush, one pulse per telegram bit, closing pause
   task automatic queue_minute(logic clean);
      logic [60:0]    frame;
      logic           raw;
      int unsigned    frame_len;
      int unsigned    gap;
      int unsigned    gap_max;
      int unsigned    width;
      int unsigned    flip_at;
      logic [31:0]    base;
      fault_kind_type fault;
      frame = 61'({$urandom, $urandom});
      raw   = !clean && ($urandom_range(0, 3) == 0);
      frame[17] = 1'($urandom_range(0, 1));
      frame[18] = !frame[17];
      frame[20] = 1'b1;
      // well-formed BCD fields unless raw digits were picked
      if (!raw) begin
         frame[27:21] = 7'(to_bcd($urandom_range(0, 59)));
         frame[34:29] = 6'(to_bcd($urandom_range(0, 23)));
         frame[41:36] = 6'(to_bcd($urandom_range(1, 31)));
         frame[44:42] = 3'($urandom_range(1, 7));
         frame[49:45] = 5'(to_bcd($urandom_range(1, 12)));
         frame[57:50] = to_bcd($urandom_range(11, 99));
      end
      frame[28] = ^frame[27:21];
      frame[35] = ^frame[34:29];
      frame[58] = ^frame[57:36];
      frame_len = TELEGRAM_BITS;
      if (!clean && $urandom_range(0, 2) == 0) begin
         fault = fault_kind_type'($urandom_range(0, 5));
         unique case (fault)
            FAULT_FLIP_BIT: begin
               flip_at = $urandom_range(0, TELEGRAM_BITS - 1);
               frame[flip_at] = !frame[flip_at];
            end
            FAULT_SHORT_COUNT: frame_len = TELEGRAM_BITS - 1;
            FAULT_LONG_COUNT:  frame_len = TELEGRAM_BITS + 1 + $urandom_range(0, 1);
            FAULT_EARLY_YEAR: begin
               frame[57:50] = to_bcd($urandom_range(0, 10));
               frame[58]    = ^frame[57:36];
            end
            FAULT_NO_START:  frame[20] = 1'b0;
            FAULT_SAME_ZONE: frame[18] = frame[17];
            default: ;
         endcase
      end
      // now and then start just short of the timestamp wrap
      if ($urandom_range(0, 2) == 0) stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 60000);
      // two low samples past the pause close any open pulse and clear the store
      repeat (2) push_at(1'b0, stamp_ms + cfg_sync_ms + 1 + $urandom_range(0, 300));
      gap_max = (cfg_sync_ms < GAP_MAX_MS) ? cfg_sync_ms : GAP_MAX_MS;
      for (int b = 0; b < frame_len; b++) begin
         gap  = $urandom_range(0, gap_max);
         base = stamp_ms;
         if ($urandom_range(0, 7) == 0) push_at(1'b0, base + gap / 2);
         push_at(1'b1, base + gap);
         width = frame[b] ? int'(cfg_one_ms) + 1 + $urandom_range(0, 120)
                          : $urandom_range(int'(cfg_zero_ms) + 1, int'(cfg_one_ms));
         base = stamp_ms;
         if ($urandom_range(0, 7) == 0) push_at(1'b1, base + width / 2);
         push_at(1'b0, base + width);
      end
      // end the minute
      push_at(1'b0, stamp_ms + cfg_sync_ms + 1 + $urandom_range(0, 300));
   endtask

   // random levels with short steps, long silences and the odd timestamp jump
   task automatic queue_noise(int unsigned count);
      int unsigned roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) stamp_ms = $urandom;
         push_at(1'($urandom_range(0, 1)),
                 stamp_ms + ((roll < 70) ? $urandom_range(0, 200) : $urandom_range(200, 5000)));
      end
   endtask

   // hold until every queued item has been taken and its result checked
   task automatic wait_drained();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_time_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register per cycle, then a write to the spare index; call at an edge
   task automatic apply_settings(logic [11:0] one_data, logic [11:0] zero_data,
                                 logic [11:0] sync_data);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_ONE_THRESHOLD;
      csr_write_data <= one_data;
      cfg_one_ms      = one_data[9:0];
      @(posedge clock);
      csr_index      <= CSR_ZERO_THRESHOLD;
      csr_write_data <= zero_data;
      cfg_zero_ms     = zero_data[9:0];
      @(posedge clock);
      csr_index      <= CSR_SYNC_PAUSE;
      csr_write_data <= sync_data;
      cfg_sync_ms     = sync_data;
      @(posedge clock);
      csr_index      <= CSR_UNUSED;
      csr_write_data <= 12'($urandom);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      settings_used++;
   endtask

   // driver: hand out queued items, advance the predictor on each one taken
   always @(posedge clock) begin : driver
      rsp_item_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
         req_hold  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = decode_sample(req_item);
            if (predicted.telegram_ok) telegrams_passed++;
            expected_time_q.push_back(predicted);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (req_hold != 0) begin
               req_hold  <= req_hold - 1;
               req_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
               req_item  <= sample_q.pop_front();
               req_valid <= 1'b1;
               req_hold  <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result item with the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_time_q.size() == 0) begin
               $error("result item arrived with no item outstanding");
               failures++;
            end else begin
               want = expected_time_q.pop_front();
               check_field("telegram_ok",   want.telegram_ok,   rsp_item.telegram_ok);
               check_field("minute_value",  want.minute_value,  rsp_item.minute_value);
               check_field("hour_value",    want.hour_value,    rsp_item.hour_value);
               check_field("day_of_month",  want.day_of_month,  rsp_item.day_of_month);
               check_field("weekday_value", want.weekday_value, rsp_item.weekday_value);
               check_field("month_value",   want.month_value,   rsp_item.month_value);
               check_field("year_value",    want.year_value,    rsp_item.year_value);
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall <= pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("run did not drain within %0d cycles", CYCLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      logic [9:0] rand_one;
      // directed samples under the reset thresholds 150, 50 and pause 1500
      push_at(1'b0, 32'd0);              // all-zero timestamp, nothing happens
      push_at(1'b1, 32'hFFFF_FFFF);      // all-ones: pause since stop 0 ends an empty minute
      push_at(1'b1, 32'hFFFF_FFFF);      // rise right after the clear
      push_at(1'b0, 32'd99);             // width 100 across the wrap: a zero bit
      push_at(1'b1, 32'd200);
      push_at(1'b0, 32'd351);            // width 151: a one bit
      push_at(1'b1, 32'd400);
      push_at(1'b0, 32'd450);            // width 50: short, pulse stays open
      push_at(1'b0, 32'd500);            // same start, width 100 now stores a zero
      push_at(1'b1, 32'd600);
      push_at(1'b0, 32'd750);            // width 150: still a zero
      push_at(1'b1, 32'd800);
      push_at(1'b0, 32'd851);            // width 51: lowest zero
      push_at(1'b1, 32'd900);
      push_at(1'b1, 32'd1000);           // held high, start unchanged
      push_at(1'b0, 32'd1200);           // width 300: a one
      push_at(1'b1, 32'd1300);
      push_at(1'b0, 32'd1300);           // zero width
      push_at(1'b0, 32'd2701);           // stores a one, so the new stop blocks the sync
      push_at(1'b0, 32'd4201);           // exactly the pause: no sync
      push_at(1'b1, 32'd4201);
      push_at(1'b0, 32'd4211);           // short fall while the pause runs out: sync
      queue_minute(1'b1);
      queue_noise(15);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // widest one threshold and pause, zero threshold 0; upper data bits must be dropped
      apply_settings(12'hFFF, 12'hC00, 12'hFFF);
      queue_minute(1'b0);
      queue_noise(15);
      wait_drained();

      // zero threshold above the one threshold and no pause at all
      apply_settings(12'h000, 12'h3FF, 12'h000);
      queue_noise(40);
      wait_drained();

      // random mid-range settings
      repeat (1) begin
         rand_one = 10'($urandom_range(60, 400));
         apply_settings(12'(rand_one), 12'($urandom_range(0, rand_one - 1)),
                        12'($urandom_range(500, 2500)));
         queue_minute(1'b0);
         queue_noise(10);
         wait_drained();
      end

      // back to the reset values
      apply_settings(12'(ONE_THRESHOLD_RESET), 12'(ZERO_THRESHOLD_RESET), SYNC_PAUSE_RESET);
      queue_minute(1'b1);
      queue_noise(10);
      wait_drained();

      $display("Checked %0d samples under %0d register settings; %0d telegrams passed decode.",
               accepted_count, settings_used, telegrams_passed);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== radio_time_code_decoder.f =====
+incdir+hdl
hdl/rtcd_pkg.sv
hdl/rtcd_cell.sv
hdl/rtcd_decode.sv
hdl/radio_time_code_decoder.sv
dv/tb_radio_time_code_decoder.sv
